// File: src/lcvsd_pkg.sv
package lcvsd_pkg;

   // voxel store geometry
   localparam int COORD_W     = 3;
   localparam int BYTE_W      = 8;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;

   // field widths
   localparam int OP_W       = 3;
   localparam int LEVEL_W    = 2;
   localparam int AXIS_W     = 3;
   localparam int ORIENT_W   = 2;
   localparam int LIT_W      = 10;
   localparam int GAP_W      = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   // brightness scale
   localparam int BRIGHT_MAX = 128;
   localparam int LIT_SCALE  = 6;
   localparam int GAP_SCALE  = 120;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 3'd0,
      OP_READ  = 3'd1,
      OP_BLANK = 3'd2,
      OP_LIGHT = 3'd3,
      OP_SCAN  = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_AXIS       = 2'd1,
      CSR_ORIENT     = 2'd2,
      CSR_FLIP_Z     = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      OUT_SEL  = 2'd0,
      OUT_READ = 2'd1,
      OUT_COL  = 2'd2
   } out_kind_type;

   // controller to datapath
   typedef struct packed {
      logic                rd_en;
      logic                rd_scan;
      logic                latch;
      logic                wr_en;
      logic                clear_all;
      logic                fill_ones;
      logic                out_load;
      out_kind_type        out_kind;
      logic                out_last;
      logic [COORD_W-1:0]  col_idx;
      logic [COORD_W-1:0]  bit_idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

   // brightness code to brightness value
   function automatic logic [BYTE_W-1:0] bright_of(input logic [LEVEL_W-1:0] level);
      logic [BYTE_W-1:0] b;
      case (level)
         2'd0:    b = 8'd0;
         2'd1:    b = 8'd10;
         2'd2:    b = 8'd40;
         default: b = 8'd128;
      endcase
      return b;
   endfunction

   function automatic logic [LIT_W-1:0] lit_of(input logic [LEVEL_W-1:0] level);
      return LIT_W'(int'(bright_of(level)) * LIT_SCALE);
   endfunction

   function automatic logic [GAP_W-1:0] gap_of(input logic [LEVEL_W-1:0] level);
      return GAP_W'((BRIGHT_MAX - int'(bright_of(level))) * GAP_SCALE);
   endfunction

endpackage

// File: src/lcvsd_ram.sv
module lcvsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lcvsd_ctrl.sv
module lcvsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [lcvsd_pkg::OP_W-1:0] req_op,
   input  lcvsd_pkg::sts_type     sts,
   output lcvsd_pkg::cmd_type     cmd
);
   import lcvsd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SET_WR   = 6'b000010,
      ST_READ_OUT = 6'b000100,
      ST_SCAN     = 6'b001000,
      ST_DRAIN    = 6'b010000,
      ST_HOLD     = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] bit_ff, bit_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      bit_in        = bit_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.out_kind  = OUT_COL;
      cmd.col_idx   = col_ff;
      cmd.bit_idx   = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.latch = 1'b1;
               case (req_op)
                  OP_SET: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_SET_WR;
                  end
                  OP_READ: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_READ_OUT;
                  end
                  OP_BLANK: begin
                     cmd.clear_all = 1'b1;
                  end
                  OP_LIGHT: begin
                     cmd.clear_all = 1'b1;
                     cmd.fill_ones = 1'b1;
                  end
                  OP_SCAN: begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = OUT_SEL;
                     col_in       = '0;
                     bit_in       = '0;
                     state_in     = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SET_WR: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_READ_OUT: begin
            cmd.out_load = 1'b1;
            cmd.out_kind = OUT_READ;
            cmd.out_last = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_scan = 1'b1;
            bit_in      = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN, ST_HOLD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_COL;
               cmd.out_last = (col_ff == 3'd7);
               col_in       = col_ff + 3'd1;
               state_in     = (col_ff == 3'd7) ? ST_IDLE : ST_SCAN;
            end else begin
               state_in = ST_HOLD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         bit_ff   <= bit_in;
      end
   end

endmodule

// File: src/lcvsd_dp.sv
module lcvsd_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lcvsd_pkg::cmd_type                  cmd,
   output lcvsd_pkg::sts_type                  sts,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_pos_x,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_pos_y,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_pos_z,
   input  logic                                req_voxel_value,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_layer,
   input  logic                                csr_valid,
   input  logic [lcvsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lcvsd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lcvsd_pkg::BYTE_W-1:0]        rsp_shift_byte,
   output logic                                rsp_voxel_bit,
   output logic                                rsp_last,
   output logic [lcvsd_pkg::LIT_W-1:0]         rsp_lit_time_us,
   output logic [lcvsd_pkg::GAP_W-1:0]         rsp_frame_gap_us
);
   import lcvsd_pkg::*;

   // configuration
   logic [LEVEL_W-1:0]  bright_ff;
   logic [AXIS_W-1:0]   axis_ff;
   logic [ORIENT_W-1:0] orient_ff;
   logic                flipz_ff;

   // latched request
   logic [ADDR_W-1:0]   addr_ff;
   logic                value_ff;
   logic [COORD_W-1:0]  layer_ff;

   // store state
   logic [STORE_DEPTH-1:0] valid_ff;
   logic                   bg_ff;

   // read pipeline
   logic                rd_pend_ff;
   logic                rd_vld_ff;
   logic [COORD_W-1:0]  rd_z_ff;
   logic [COORD_W-1:0]  rd_k_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic [COORD_W-1:0]  rd_z_in;
   logic [BYTE_W-1:0]   ram_q;
   logic [BYTE_W-1:0]   byte_eff;
   logic                cur_bit;
   logic [BYTE_W-1:0]   wr_byte;

   // column accumulator
   logic [BYTE_W-1:0]   acc_ff, acc_in;

   // scan remap
   logic [COORD_W-1:0]  sx, sy, sz, ty, tz, fy, fz;

   // output register
   logic                out_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_bit_ff, out_bit_in;
   logic                out_last_ff;
   logic [LIT_W-1:0]    out_lit_ff, out_lit_in;
   logic [GAP_W-1:0]    out_gap_ff, out_gap_in;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= '0;
         axis_ff   <= '0;
         orient_ff <= '0;
         flipz_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BRIGHTNESS: bright_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_AXIS:       axis_ff   <= csr_wdata[AXIS_W-1:0];
            CSR_ORIENT:     orient_ff <= csr_wdata[ORIENT_W-1:0];
            CSR_FLIP_Z:     flipz_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // axis permutation, then y/z swap, y flip, z flip
   always_comb begin
      case (axis_ff)
         3'd1: begin
            sx = cmd.bit_idx;  sy = layer_ff;     sz = cmd.col_idx;
         end
         3'd2: begin
            sx = cmd.col_idx;  sy = cmd.bit_idx;  sz = layer_ff;
         end
         3'd3: begin
            sx = ~layer_ff;    sy = cmd.col_idx;  sz = cmd.bit_idx;
         end
         3'd4: begin
            sx = ~cmd.bit_idx; sy = layer_ff;     sz = cmd.col_idx;
         end
         3'd5: begin
            sx = ~cmd.col_idx; sy = cmd.bit_idx;  sz = layer_ff;
         end
         default: begin
            sx = layer_ff;     sy = cmd.col_idx;  sz = cmd.bit_idx;
         end
      endcase
      ty = orient_ff[1] ? sz : sy;
      tz = orient_ff[1] ? sy : sz;
      fy = orient_ff[0] ? ~ty : ty;
      fz = flipz_ff ? ~tz : tz;
   end

   // read address: point ops use y*8+x, scan uses x*8+y
   assign rd_addr = cmd.rd_scan ? {sx, fy} : {req_pos_y, req_pos_x};
   assign rd_z_in = cmd.rd_scan ? fz : req_pos_z;

   lcvsd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // an entry not written since the last blank or light reads as background
   assign byte_eff = rd_vld_ff ? ram_q : {BYTE_W{bg_ff}};
   assign cur_bit  = byte_eff[rd_z_ff];

   // read-modify-write data for a set
   always_comb begin
      wr_byte          = byte_eff;
      wr_byte[rd_z_ff] = value_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (rd_pend_ff) begin
         acc_in[rd_k_ff] = cur_bit;
      end
   end

   // read pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
      end
   end

   // read pipeline payload and request latch
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_vld_ff <= valid_ff[rd_addr];
         rd_z_ff   <= rd_z_in;
         rd_k_ff   <= cmd.bit_idx;
      end
      if (cmd.latch) begin
         addr_ff  <= {req_pos_y, req_pos_x};
         value_ff <= req_voxel_value;
         layer_ff <= req_layer;
      end
      acc_ff <= acc_in;
   end

   // entry valid bits and background level
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         bg_ff    <= 1'b0;
      end else if (cmd.clear_all) begin
         valid_ff <= '0;
         bg_ff    <= cmd.fill_ones;
      end else if (cmd.wr_en) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // output register
   assign sts.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // next output word by kind
   always_comb begin
      out_byte_in = '0;
      out_bit_in  = 1'b0;
      out_lit_in  = '0;
      out_gap_in  = '0;
      case (cmd.out_kind)
         OUT_SEL: begin
            out_byte_in = BYTE_W'(1) << req_layer;
         end
         OUT_READ: begin
            out_bit_in = cur_bit;
         end
         OUT_COL: begin
            out_byte_in = acc_in;
            if (cmd.out_last) begin
               out_lit_in = lit_of(bright_ff);
               out_gap_in = gap_of(bright_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_byte_ff <= out_byte_in;
         out_bit_ff  <= out_bit_in;
         out_last_ff <= cmd.out_last;
         out_lit_ff  <= out_lit_in;
         out_gap_ff  <= out_gap_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_shift_byte   = out_byte_ff;
   assign rsp_voxel_bit    = out_bit_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_lit_time_us  = out_lit_ff;
   assign rsp_frame_gap_us = out_gap_ff;

endmodule

// File: src/led_cube_voxel_scan_driver.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  op, pos_x, pos_y, pos_z, voxel_value, layer
// rsp       out        rsp_valid/rsp_ready  shift_byte, voxel_bit, last, lit_time_us,
//                                           frame_gap_us
// csr       in         csr_valid/csr_ready  index, wdata (always ready)
//
// set voxel reads then writes back its entry, read voxel reads it out, blank and light clear the valid bits.
// a layer scan does 8 store reads per column byte through the
// single read port of the voxel store, plus a drain state per column.
// synchronous reset clears config, control and the 64 entry valid bits at once.
// a new word is taken only when the control is idle and the output register is
// free or being emptied; a stalled output holds the scan between columns.
module led_cube_voxel_scan_driver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lcvsd_pkg::OP_W-1:0]          req_op,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_pos_x,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_pos_y,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_pos_z,
   input  logic                                req_voxel_value,
   input  logic [lcvsd_pkg::COORD_W-1:0]       req_layer,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lcvsd_pkg::BYTE_W-1:0]        rsp_shift_byte,
   output logic                                rsp_voxel_bit,
   output logic                                rsp_last,
   output logic [lcvsd_pkg::LIT_W-1:0]         rsp_lit_time_us,
   output logic [lcvsd_pkg::GAP_W-1:0]         rsp_frame_gap_us,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcvsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lcvsd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lcvsd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   lcvsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd)
   );

   // store, remap and output register
   lcvsd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_voxel_value  (req_voxel_value),
      .req_layer        (req_layer),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shift_byte   (rsp_shift_byte),
      .rsp_voxel_bit    (rsp_voxel_bit),
      .rsp_last         (rsp_last),
      .rsp_lit_time_us  (rsp_lit_time_us),
      .rsp_frame_gap_us (rsp_frame_gap_us)
   );

`ifndef SYNTH
   // a word is only taken when the output register can take a result
   a_ready_out_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("input taken while output register blocked");

   // a voxel read answers through the store read and the output register with a single last word
   a_read_answer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_READ) |=> ##1 (rsp_valid && rsp_last))
      else $error("voxel read did not answer");

   // a scan opens with the one-hot layer select
   a_scan_select: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_SCAN) |=>
      (rsp_valid && !rsp_last && rsp_shift_byte == (8'd1 << $past(req_layer))))
      else $error("scan did not start with layer select");

   // timing fields only ride on the closing word
   a_lit_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_lit_time_us != '0) |-> rsp_last)
      else $error("lit time on a non-final word");
`endif

endmodule

// File: tb/sv/voxel_scan_checker.sv
`timescale 1ns / 100ps

module voxel_scan_checker
   import lcvsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COORD_W-1:0]    req_pos_z,
   input  logic                  req_voxel_value,
   input  logic [COORD_W-1:0]    req_layer,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [BYTE_W-1:0]     rsp_shift_byte,
   input  logic                  rsp_voxel_bit,
   input  logic                  rsp_last,
   input  logic [LIT_W-1:0]      rsp_lit_time_us,
   input  logic [GAP_W-1:0]      rsp_frame_gap_us,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   // scan index to cube axis mappings, the upper three mirror x
   typedef enum logic [AXIS_W-1:0] {
      MAP_LJK        = 3'd0,
      MAP_KLJ        = 3'd1,
      MAP_JKL        = 3'd2,
      MAP_LJK_MIRROR = 3'd3,
      MAP_KLJ_MIRROR = 3'd4,
      MAP_JKL_MIRROR = 3'd5
   } axis_map_type;

   localparam int ORIENT_SWAP_BIT   = 1;
   localparam int ORIENT_FLIP_Y_BIT = 0;
   localparam int REPORT_LIMIT      = 10;
   localparam int unsigned BRIGHT_STEPS [4] = '{0, 10, 40, 128};

   typedef struct packed {
      logic [BYTE_W-1:0] shift_byte;
      logic              voxel_bit;
      logic              last;
      logic [LIT_W-1:0]  lit_time_us;
      logic [GAP_W-1:0]  frame_gap_us;
   } cube_word_type;

   // shadow of the cube and of the registers
   logic [BYTE_W-1:0]   voxels [STORE_DEPTH];
   logic [LEVEL_W-1:0]  level;
   logic [AXIS_W-1:0]   axis_sel;
   logic [ORIENT_W-1:0] orient;
   logic                z_mirror;

   cube_word_type expected_words [$];
   int err_count = 0;
   int word_count = 0;

   // one column byte of a layer scan, through the active remap
   function automatic logic [BYTE_W-1:0] column_byte(input logic [COORD_W-1:0] lyr,
                                                     input logic [COORD_W-1:0] col);
      logic [COORD_W-1:0] x, y, z, t, kb;
      logic [BYTE_W-1:0]  b;
      int k;
      b = '0;
      for (k = 0; k < 8; k++) begin
         kb = COORD_W'(k);
         case (axis_sel)
            MAP_KLJ:        begin x = kb;          y = lyr; z = col; end
            MAP_JKL:        begin x = col;         y = kb;  z = lyr; end
            MAP_LJK_MIRROR: begin x = 3'd7 - lyr;  y = col; z = kb;  end
            MAP_KLJ_MIRROR: begin x = 3'd7 - kb;   y = lyr; z = col; end
            MAP_JKL_MIRROR: begin x = 3'd7 - col;  y = kb;  z = lyr; end
            // the two unused codes fall back to the plain mapping
            default:        begin x = lyr;         y = col; z = kb;  end
         endcase
         if (orient[ORIENT_SWAP_BIT]) begin
            t = z;
            z = y;
            y = t;
         end
         if (orient[ORIENT_FLIP_Y_BIT]) y = 3'd7 - y;
         if (z_mirror) z = 3'd7 - z;
         b[k] = voxels[{x, y}][z];
      end
      return b;
   endfunction

   always @(posedge clock) begin : watch
      cube_word_type want, got;
      int unsigned bright;
      int j;
      if (reset) begin
         for (j = 0; j < STORE_DEPTH; j++) voxels[j] = '0;
         level    = '0;
         axis_sel = '0;
         orient   = '0;
         z_mirror = 1'b0;
         expected_words.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BRIGHTNESS: level    = csr_wdata[LEVEL_W-1:0];
               CSR_AXIS:       axis_sel = csr_wdata[AXIS_W-1:0];
               CSR_ORIENT:     orient   = csr_wdata[ORIENT_W-1:0];
               CSR_FLIP_Z:     z_mirror = csr_wdata[0];
               default: ;
            endcase
         end

         // outgoing words, checked before this edge's request adds any
         if (rsp_valid && rsp_ready) begin
            got.shift_byte   = rsp_shift_byte;
            got.voxel_bit    = rsp_voxel_bit;
            got.last         = rsp_last;
            got.lit_time_us  = rsp_lit_time_us;
            got.frame_gap_us = rsp_frame_gap_us;
            if (expected_words.size() == 0) begin
               if (err_count < REPORT_LIMIT)
                  $display("[%0t] unexpected word %0d: byte=%h bit=%b last=%b lit=%0d gap=%0d",
                           $realtime, word_count, got.shift_byte, got.voxel_bit, got.last,
                           got.lit_time_us, got.frame_gap_us);
               err_count++;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  if (err_count < REPORT_LIMIT)
                     $display({"[%0t] word %0d mismatch: expected byte=%h bit=%b last=%b ",
                               "lit=%0d gap=%0d, got byte=%h bit=%b last=%b lit=%0d gap=%0d"},
                              $realtime, word_count, want.shift_byte, want.voxel_bit,
                              want.last, want.lit_time_us, want.frame_gap_us,
                              got.shift_byte, got.voxel_bit, got.last, got.lit_time_us,
                              got.frame_gap_us);
                  err_count++;
               end
            end
            word_count++;
         end

         // accepted requests update the shadow cube and queue their words
         if (req_valid && req_ready) begin
            case (req_op)
               OP_SET:
                  voxels[{req_pos_y, req_pos_x}][req_pos_z] = req_voxel_value;
               OP_READ: begin
                  want = '0;
                  want.voxel_bit = voxels[{req_pos_y, req_pos_x}][req_pos_z];
                  want.last      = 1'b1;
                  expected_words.push_back(want);
               end
               OP_BLANK:
                  for (j = 0; j < STORE_DEPTH; j++) voxels[j] = '0;
               OP_LIGHT:
                  for (j = 0; j < STORE_DEPTH; j++) voxels[j] = '1;
               OP_SCAN: begin
                  want = '0;
                  want.shift_byte = BYTE_W'(1) << req_layer;
                  expected_words.push_back(want);
                  bright = BRIGHT_STEPS[level];
                  for (j = 0; j < 8; j++) begin
                     want = '0;
                     want.shift_byte = column_byte(req_layer, COORD_W'(j));
                     if (j == 7) begin
                        want.last         = 1'b1;
                        want.lit_time_us  = LIT_W'(bright * LIT_SCALE);
                        want.frame_gap_us = GAP_W'((BRIGHT_MAX - bright) * GAP_SCALE);
                     end
                     expected_words.push_back(want);
                  end
               end
               // unused codes are dropped by the block
               default: ;
            endcase
         end
      end
      outstanding <= expected_words.size();
      mismatches  <= err_count;
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import lcvsd_pkg::*;

   localparam int          RESET_CYCLES    = 10;
   localparam int          SETTLE_CYCLES   = 32;
   localparam int          PHASE_COUNT     = 8;
   localparam int          PHASE_ITEMS     = 14;
   localparam int          CYCLE_LIMIT     = 500000;
   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

   logic clock = 1'b0;
   logic reset;

   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op;
   logic [COORD_W-1:0]    req_pos_x;
   logic [COORD_W-1:0]    req_pos_y;
   logic [COORD_W-1:0]    req_pos_z;
   logic                  req_voxel_value;
   logic [COORD_W-1:0]    req_layer;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_shift_byte;
   logic                  rsp_voxel_bit;
   logic                  rsp_last;
   logic [LIT_W-1:0]      rsp_lit_time_us;
   logic [GAP_W-1:0]      rsp_frame_gap_us;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int outstanding;
   int unsigned cycle_count = 0;
   int unsigned sender_pct = 0;
   int unsigned receiver_pct = 0;

   led_cube_voxel_scan_driver dut (.*);

   voxel_scan_checker cube_check (.*);

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_pct);
   end

   // present one request word, with an optional idle gap ahead of it
   task automatic send_word(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                            input logic v, input logic [COORD_W-1:0] lyr);
      if (sender_pct != 0 && $urandom_range(0, 99) < sender_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_pct);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_pos_z       <= z;
      req_voxel_value <= v;
      req_layer       <= lyr;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every queued word has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [LEVEL_W-1:0] lvl, input logic [AXIS_W-1:0] axis,
                            input logic [ORIENT_W-1:0] orient, input logic flip);
      write_reg(CSR_BRIGHTNESS, CSR_DATA_W'(lvl));
      write_reg(CSR_AXIS, CSR_DATA_W'(axis));
      write_reg(CSR_ORIENT, CSR_DATA_W'(orient));
      write_reg(CSR_FLIP_Z, CSR_DATA_W'(flip));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned count;
      int unsigned pick;
      int phase;
      logic [OP_W-1:0] op;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_SET;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pos_z       = '0;
      req_voxel_value = 1'b0;
      req_layer       = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_BRIGHTNESS;
      csr_wdata       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, addressing order, every op, unused codes, fill and clear
      send_word(OP_READ,  3'd0, 3'd0, 3'd0, 1'b0, 3'd0);
      send_word(OP_SET,   3'd0, 3'd0, 3'd0, 1'b1, 3'd0);
      send_word(OP_SET,   3'd7, 3'd7, 3'd7, 1'b1, 3'd7);
      send_word(OP_SET,   3'd5, 3'd2, 3'd6, 1'b1, 3'd0);
      send_word(OP_READ,  3'd0, 3'd0, 3'd0, 1'b0, 3'd0);
      send_word(OP_READ,  3'd7, 3'd7, 3'd7, 1'b0, 3'd0);
      send_word(OP_READ,  3'd2, 3'd5, 3'd6, 1'b0, 3'd0);
      send_word(OP_SCAN,  3'd0, 3'd0, 3'd0, 1'b0, 3'd0);
      send_word(OP_SCAN,  3'd0, 3'd0, 3'd0, 1'b0, 3'd7);
      send_word(OP_SCAN,  3'd0, 3'd0, 3'd0, 1'b0, 3'd5);
      send_word(OP_SET,   3'd7, 3'd7, 3'd7, 1'b0, 3'd0);
      send_word(OP_READ,  3'd7, 3'd7, 3'd7, 1'b0, 3'd0);
      send_word(OP_FIRST_UNUSED, 3'd1, 3'd1, 3'd1, 1'b1, 3'd1);
      send_word(OP_FIRST_UNUSED + 3'd1, 3'd2, 3'd2, 3'd2, 1'b0, 3'd2);
      send_word(OP_LAST_UNUSED, 3'd7, 3'd7, 3'd7, 1'b1, 3'd7);
      send_word(OP_LIGHT, 3'd0, 3'd0, 3'd0, 1'b0, 3'd0);
      send_word(OP_READ,  3'd3, 3'd4, 3'd1, 1'b0, 3'd0);
      send_word(OP_SCAN,  3'd0, 3'd0, 3'd0, 1'b0, 3'd3);
      send_word(OP_SET,   3'd3, 3'd4, 3'd1, 1'b0, 3'd0);
      send_word(OP_SCAN,  3'd0, 3'd0, 3'd0, 1'b0, 3'd4);
      send_word(OP_BLANK, 3'd0, 3'd0, 3'd0, 1'b0, 3'd0);
      send_word(OP_READ,  3'd3, 3'd3, 3'd3, 1'b0, 3'd0);
      send_word(OP_SCAN,  3'd0, 3'd0, 3'd0, 1'b0, 3'd1);

      // random phases, each setting the registers and the pacing anew
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         case (phase)
            0: configure(2'd0, 3'd0, 2'd0, 1'b0);
            1: configure(2'd3, 3'd5, 2'd3, 1'b1);
            2: configure(2'd1, 3'd6, 2'd1, 1'b0);
            3: configure(2'd2, 3'd7, 2'd2, 1'b1);
            default: configure(LEVEL_W'($urandom_range(0, 3)), AXIS_W'($urandom_range(0, 7)),
                               ORIENT_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         endcase
         case (phase % 4)
            0:       begin sender_pct = 0;  receiver_pct = 0;  end
            1:       begin sender_pct = 76; receiver_pct = 0;  end
            2:       begin sender_pct = 0;  receiver_pct = 76; end
            default: begin sender_pct = 22; receiver_pct = 22; end
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            if (phase == 2 && count == PHASE_ITEMS / 2) wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 34)      op = OP_SET;
            else if (pick < 54) op = OP_READ;
            else if (pick < 82) op = OP_SCAN;
            else if (pick < 86) op = OP_LIGHT;
            else if (pick < 92) op = OP_BLANK;
            else                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            send_word(op, COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
                      COORD_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      COORD_W'($urandom_range(0, 7)));
            if (op < OP_FIRST_UNUSED) count++;
         end
      end

      wait_idle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: led_cube_voxel_scan_driver.f
src/lcvsd_pkg.sv
src/lcvsd_ram.sv
src/lcvsd_ctrl.sv
src/lcvsd_dp.sv
src/led_cube_voxel_scan_driver.sv
tb/sv/voxel_scan_checker.sv
tb/sv/tb.sv
